>>> rtl/assert_macros.svh
// Assertion macros shared by the deadband detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies c in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("implication check failed");

// Condition a implies c in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("next-cycle check failed");

// Condition a never holds.
`define ASSERT_NEVER(lbl, clk, rstn, a) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(a)) \
    else $error("forbidden condition seen");

`endif

>>> rtl/pndcd_pkg.sv
// Shared types and constants of the per-node deadband change detector.
`default_nettype none

package pndcd_pkg;

  // Word layout on the stream ports
  localparam int NODE_W      = 4;
  localparam int COUNT_W     = 4;
  localparam int READING_W   = 32;
  localparam int IN_LANES    = 8;
  localparam int IN_TDATA_W  = 264;
  localparam int OUT_TDATA_W = 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b1;

  localparam logic [READING_W-1:0] THRESHOLD_RESET = 32'h0001_0000;

  // Verdict for one record
  typedef struct packed {
    logic forward;
    logic rejected;
  } decision_t;

endpackage

`default_nettype wire

>>> rtl/pndcd_lane.sv
// One reading lane: baseline memory, last-write bypass and deadband compare.
`default_nettype none

module pndcd_lane #(
  parameter int NODE_COUNT = 16,
  parameter int SLOT_W     = 4
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               rd_en_i,
  input  wire logic [SLOT_W-1:0]                  rd_addr_i,
  input  wire logic [SLOT_W-1:0]                  cmp_slot_i,
  input  wire logic [pndcd_pkg::READING_W-1:0]    cmp_cur_i,
  input  wire logic                               cmp_active_i,
  input  wire logic [pndcd_pkg::READING_W-1:0]    thresh_i,
  input  wire logic                               wr_en_i,
  output logic                                    hit_o
);
  import pndcd_pkg::*;

  logic [READING_W-1:0] mem_q [NODE_COUNT];
  logic [READING_W-1:0] rd_q;
  logic                 byp_v_q;
  logic [SLOT_W-1:0]    byp_slot_q;
  logic [READING_W-1:0] byp_data_q;
  logic [READING_W-1:0] base;
  logic signed [READING_W+1:0] cur_x, base_x, thr_x, diff_hi, diff_lo;

  // Baseline memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[cmp_slot_i] <= cmp_cur_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Last write of this lane, covers a read issued on the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_v_q <= 1'b0;
    end else if (wr_en_i) begin
      byp_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      byp_slot_q <= cmp_slot_i;
      byp_data_q <= cmp_cur_i;
    end
  end

  assign base = (byp_v_q && (byp_slot_q == cmp_slot_i)) ? byp_data_q : rd_q;

  // |cur - base| >= thr  <=>  cur-base-thr >= 0  or  cur-base+thr <= 0
  always_comb begin
    cur_x   = {{2{cmp_cur_i[READING_W-1]}}, cmp_cur_i};
    base_x  = {{2{base[READING_W-1]}}, base};
    thr_x   = {2'b00, thresh_i};
    diff_hi = cur_x - base_x - thr_x;
    diff_lo = cur_x - base_x + thr_x;
    hit_o   = cmp_active_i &&
              (!diff_hi[READING_W+1] || diff_lo[READING_W+1] || (diff_lo == '0));
  end

endmodule

`default_nettype wire

>>> rtl/pndcd_merge.sv
// Merge of lane hits with per-node baseline-valid flags into the verdict.
`default_nettype none

`include "assert_macros.svh"

module pndcd_merge #(
  parameter int NODE_COUNT = 16,
  parameter int LANE_COUNT = 8,
  parameter int SLOT_W     = 4
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [LANE_COUNT-1:0]            hits_i,
  input  wire logic [pndcd_pkg::NODE_W-1:0]     node_id_i,
  input  wire logic [pndcd_pkg::COUNT_W-1:0]    field_count_i,
  input  wire logic                             enable_i,
  input  wire logic                             commit_i,
  output pndcd_pkg::decision_t                  dec_o,
  output logic                                  wr_en_o
);
  import pndcd_pkg::*;

  logic [NODE_COUNT-1:0] valid_q;
  logic [SLOT_W-1:0]     slot;
  logic                  in_range;
  logic                  count_ok;

  assign slot     = SLOT_W'(node_id_i);
  assign in_range = int'(node_id_i) < NODE_COUNT;
  assign count_ok = int'(field_count_i) <= LANE_COUNT;

  // Verdict: reject first, else forward on missing baseline or any hit
  always_comb begin
    dec_o.rejected = !enable_i || !count_ok || !in_range;
    dec_o.forward  = !dec_o.rejected && (!valid_q[slot] || (|hits_i));
    wr_en_o        = commit_i && dec_o.forward;
  end

  // Baseline-valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_o) begin
      valid_q[slot] <= 1'b1;
    end
  end

  `ASSERT_NEXT(a_valid_set, clk_i, rst_ni, wr_en_o, valid_q[$past(slot)])
  `ASSERT_NEVER(a_no_fwd_rej, clk_i, rst_ni, dec_o.forward && dec_o.rejected)

endmodule

`default_nettype wire

>>> rtl/per_node_deadband_change_detector_core.sv
// Top level of the per-node deadband change detector.
//
// Input stream (s_axis): one word per telemetry record holding node number,
// valid field count and eight signed Q16.16 readings. Output stream (m_axis):
// one word per record with forward, rejected and the echoed node number.
// Configuration: cfg_we_i writes register cfg_idx_i (0 enable, 1 threshold)
// with cfg_wdata_i on the rising edge; write only while no record is in flight.
// A record accepted on s_axis passes the compare stage and output registers
// to m_axis. Throughput: one record per cycle unless m_axis stalls; the lanes
// compare in parallel and each lane's baseline memory takes one read and one
// write per cycle, with a last-write bypass for back-to-back same-node records.
// Reset: enable cleared, threshold 1.0, all baseline-valid flags cleared;
// baseline memories are not cleared and hold no defined value until written.
// Stall: the output register holds its word while m_axis_tready is low; one
// more record can enter the compare stage, after which s_axis_tready drops.
`default_nettype none

`include "assert_macros.svh"

module per_node_deadband_change_detector_core #(
  parameter int NODE_COUNT = 16,
  parameter int LANE_COUNT = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Record stream in
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // node_id[3:0], field_count[7:4], reading_0[39:8] ... reading_7[263:232]
  input  wire logic [pndcd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Verdict stream out
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // forward[0], rejected[1], node_out[5:2], zero[7:6]
  output logic [pndcd_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // Configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [pndcd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [pndcd_pkg::READING_W-1:0]     cfg_wdata_i
);
  import pndcd_pkg::*;

  localparam int SLOT_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  // Configuration registers
  logic                 enable_q;
  logic [READING_W-1:0] thresh_q;

  // Compare stage
  logic                 s1_v_q;
  logic [NODE_W-1:0]    s1_node_q;
  logic [COUNT_W-1:0]   s1_count_q;
  logic [READING_W-1:0] s1_rd_q [LANE_COUNT];

  // Output register
  logic                 out_v_q;
  logic                 out_fwd_q;
  logic                 out_rej_q;
  logic [NODE_W-1:0]    out_node_q;

  logic                  s1_adv;
  logic                  in_acc;
  logic                  commit;
  logic                  wr_en;
  logic [LANE_COUNT-1:0] hits;
  logic [LANE_COUNT-1:0] active;
  decision_t             dec;

  assign s1_adv        = !out_v_q || m_axis_tready;
  assign s_axis_tready = !s1_v_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign commit        = s1_v_q && s1_adv;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      thresh_q <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENABLE:    enable_q <= cfg_wdata_i[0];
        REG_THRESHOLD: thresh_q <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // Compare stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  // Compare stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_node_q  <= s_axis_tdata[NODE_W-1:0];
      s1_count_q <= s_axis_tdata[NODE_W +: COUNT_W];
      for (int l = 0; l < LANE_COUNT; l++) begin
        s1_rd_q[l] <= s_axis_tdata[NODE_W + COUNT_W + READING_W*l +: READING_W];
      end
    end
  end

  // Lanes: one baseline memory and comparator each
  for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
    assign active[l] = int'(s1_count_q) > l;

    pndcd_lane #(
      .NODE_COUNT (NODE_COUNT),
      .SLOT_W     (SLOT_W)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .rd_en_i      (in_acc),
      .rd_addr_i    (SLOT_W'(s_axis_tdata[NODE_W-1:0])),
      .cmp_slot_i   (SLOT_W'(s1_node_q)),
      .cmp_cur_i    (s1_rd_q[l]),
      .cmp_active_i (active[l]),
      .thresh_i     (thresh_q),
      .wr_en_i      (wr_en && active[l]),
      .hit_o        (hits[l])
    );
  end

  // Verdict and baseline-valid flags
  pndcd_merge #(
    .NODE_COUNT (NODE_COUNT),
    .LANE_COUNT (LANE_COUNT),
    .SLOT_W     (SLOT_W)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .hits_i        (hits),
    .node_id_i     (s1_node_q),
    .field_count_i (s1_count_q),
    .enable_i      (enable_q),
    .commit_i      (commit),
    .dec_o         (dec),
    .wr_en_o       (wr_en)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_fwd_q  <= dec.forward;
      out_rej_q  <= dec.rejected;
      out_node_q <= s1_node_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, out_node_q, out_rej_q, out_fwd_q};

  `ASSERT_NEVER(a_out_fwd_rej, clk_i, rst_ni, m_axis_tvalid && out_fwd_q && out_rej_q)
  `ASSERT_IMPLIES(a_stall_blocks, clk_i, rst_ni, s1_v_q && out_v_q && !m_axis_tready, !s_axis_tready)
  `ASSERT_NEXT(a_commit_out, clk_i, rst_ni, commit, out_v_q)

endmodule

`default_nettype wire
